### rtl/otsu_pkg.sv
// Shared types and constants of the Otsu threshold finder.
package otsu_pkg;

   // Grey level that is never counted, and the highest level that is.
   localparam logic [7:0] PIX_SKIP = 8'd255;
   localparam logic [7:0] LAST_BIN = 8'd254;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_INC,
      OP_SW_INIT,
      OP_SW_RD,
      OP_SW_ACC,
      OP_SET_THR,
      OP_SC_RD,
      OP_SC_ACC,
      OP_DECIDE,
      OP_CLEAR
   } dp_op_type;

   typedef enum logic [2:0] {
      MS_P,
      MS_Q,
      MS_DEN,
      MS_SQ,
      MS_LHS,
      MS_RHS
   } mul_sel_type;

   typedef struct packed {
      dp_op_type   op;
      mul_sel_type msel;
      logic        mul_go;
      logic        mul_take;
   } dp_cmd_type;

   typedef struct packed {
      logic       mul_busy;
      logic       mul_done;
      logic       sweep_end;
      logic       found;
      logic       narrow;
      logic       scan_end;
      logic [7:0] threshold;
   } dp_stat_type;

endpackage

### rtl/otsu_req_if.sv
// Request channel: one grey pixel and its end-of-frame flag.
interface otsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel;
   logic       last_pixel;

   modport source (output valid, output pixel, output last_pixel, input ready);
   modport sink (input valid, input pixel, input last_pixel, output ready);
endinterface

### rtl/otsu_rsp_if.sv
// Response channel: the threshold of a completed frame.
interface otsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] threshold;

   modport source (output valid, output threshold, input ready);
   modport sink (input valid, input threshold, output ready);
endinterface

### rtl/otsu_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, early exit on zero.
module otsu_mul #(
   parameter int AW = 112,
   parameter int BW = 56
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  logic [AW-1:0]     a_in,
   input  logic [BW-1:0]     b_in,
   output logic              busy,
   output logic              done,
   output logic [AW+BW-1:0]  product
);
   localparam int PW = AW + BW;

   logic          busy_ff;
   logic [PW-1:0] a_ff;
   logic [BW-1:0] b_ff;
   logic [PW-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (go) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && (b_ff == '0)) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         a_ff   <= PW'(a_in);
         b_ff   <= b_in;
         acc_ff <= '0;
      end else if (busy_ff && (b_ff != '0)) begin
         if (b_ff[0]) begin
            acc_ff <= acc_ff + a_ff;
         end
         a_ff <= a_ff << 1;
         b_ff <= b_ff >> 1;
      end
   end

   assign busy    = busy_ff;
   assign done    = busy_ff && (b_ff == '0);
   assign product = acc_ff;
endmodule

### rtl/otsu_dp.sv
// Datapath: histogram memory, sweep and scan registers, variance compare.
module otsu_dp #(
   parameter int COUNT_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           req_pixel,
   input  otsu_pkg::dp_cmd_type cmd,
   output otsu_pkg::dp_stat_type stat
);
   localparam int CW   = COUNT_BITS;
   localparam int TCW  = CW + 8;
   localparam int TWW  = CW + 16;
   localparam int NUMW = TWW + TCW;
   localparam int DENW = 2 * TCW;
   localparam int SQW  = 2 * NUMW;
   localparam int PW   = SQW + NUMW;

   logic [CW-1:0]   hist_mem [256];
   logic [255:0]    vld_ff;
   logic [CW-1:0]   rd_data_ff;
   logic            rd_vld_ff;
   logic [7:0]      pix_ff;
   logic [7:0]      idx_ff;
   logic [7:0]      lo_ff;
   logic [7:0]      hi_ff;
   logic            found_ff;
   logic            first_ff;
   logic [7:0]      thr_ff;
   logic [TCW-1:0]  tc_ff;
   logic [TWW-1:0]  tw_ff;
   logic [TCW-1:0]  pb_ff;
   logic [TWW-1:0]  ib_ff;
   logic [NUMW-1:0] p_ff;
   logic [NUMW-1:0] num_ff;
   logic [DENW-1:0] den_ff;
   logic [SQW-1:0]  sq_ff;
   logic [PW-1:0]   lhs_ff;
   logic [PW-1:0]   rhs_ff;
   logic [SQW-1:0]  bsq_ff;
   logic [DENW-1:0] bden_ff;

   logic [CW-1:0]   bin;
   logic [TWW-1:0]  bin_w;
   logic [7:0]      rd_addr;
   logic            rd_en;
   logic            inc_en;
   logic [SQW-1:0]  op_a;
   logic [NUMW-1:0] op_b;
   logic            mul_busy;
   logic            mul_done;
   logic [PW-1:0]   mul_prod;
   logic [NUMW-1:0] q_val;

   assign bin    = rd_vld_ff ? rd_data_ff : '0;
   assign bin_w  = TWW'(bin) * TWW'(idx_ff);
   assign rd_en  = (cmd.op == otsu_pkg::OP_LOAD) || (cmd.op == otsu_pkg::OP_SW_RD) ||
                   (cmd.op == otsu_pkg::OP_SC_RD);
   assign rd_addr = (cmd.op == otsu_pkg::OP_LOAD) ? req_pixel : idx_ff;
   assign inc_en = (cmd.op == otsu_pkg::OP_INC) && (pix_ff != otsu_pkg::PIX_SKIP) &&
                   (bin != '1);
   assign q_val  = mul_prod[NUMW-1:0];

   // Histogram storage, registered read.
   always_ff @(posedge clock) begin
      if (inc_en) begin
         hist_mem[pix_ff] <= bin + 1'b1;
      end
      if (rd_en) begin
         rd_data_ff <= hist_mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.op == otsu_pkg::OP_CLEAR) begin
         vld_ff <= '0;
      end else if (inc_en) begin
         vld_ff[pix_ff] <= 1'b1;
      end
   end

   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (cmd.msel)
         otsu_pkg::MS_P: begin
            op_a = SQW'(ib_ff);
            op_b = NUMW'(tc_ff);
         end
         otsu_pkg::MS_Q: begin
            op_a = SQW'(tw_ff);
            op_b = NUMW'(pb_ff);
         end
         otsu_pkg::MS_DEN: begin
            op_a = SQW'(pb_ff);
            op_b = NUMW'(tc_ff - pb_ff);
         end
         otsu_pkg::MS_SQ: begin
            op_a = SQW'(num_ff);
            op_b = num_ff;
         end
         otsu_pkg::MS_LHS: begin
            op_a = sq_ff;
            op_b = NUMW'(bden_ff);
         end
         otsu_pkg::MS_RHS: begin
            op_a = bsq_ff;
            op_b = NUMW'(den_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   otsu_mul #(
      .AW(SQW),
      .BW(NUMW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .go      (cmd.mul_go),
      .a_in    (op_a),
      .b_in    (op_b),
      .busy    (mul_busy),
      .done    (mul_done),
      .product (mul_prod)
   );

   // Capture products.
   always_ff @(posedge clock) begin
      if (cmd.mul_take) begin
         unique case (cmd.msel)
            otsu_pkg::MS_P:   p_ff   <= mul_prod[NUMW-1:0];
            otsu_pkg::MS_Q:   num_ff <= (p_ff >= q_val) ? (p_ff - q_val) : (q_val - p_ff);
            otsu_pkg::MS_DEN: den_ff <= mul_prod[DENW-1:0];
            otsu_pkg::MS_SQ:  sq_ff  <= mul_prod[SQW-1:0];
            otsu_pkg::MS_LHS: lhs_ff <= mul_prod;
            otsu_pkg::MS_RHS: rhs_ff <= mul_prod;
            default: ;
         endcase
      end
   end

   // Sweep and scan registers.
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         otsu_pkg::OP_LOAD: begin
            pix_ff <= req_pixel;
         end
         otsu_pkg::OP_SW_INIT: begin
            idx_ff   <= '0;
            lo_ff    <= '0;
            hi_ff    <= '0;
            found_ff <= 1'b0;
            tc_ff    <= '0;
            tw_ff    <= '0;
         end
         otsu_pkg::OP_SW_ACC: begin
            if (bin != '0) begin
               if (!found_ff) begin
                  lo_ff <= idx_ff;
               end
               found_ff <= 1'b1;
               hi_ff    <= idx_ff;
               tc_ff    <= tc_ff + TCW'(bin);
               tw_ff    <= tw_ff + bin_w;
            end
            idx_ff <= idx_ff + 8'd1;
         end
         otsu_pkg::OP_SET_THR: begin
            thr_ff   <= found_ff ? lo_ff : 8'd0;
            idx_ff   <= lo_ff;
            pb_ff    <= '0;
            ib_ff    <= '0;
            bsq_ff   <= '0;
            bden_ff  <= '0;
            first_ff <= 1'b1;
         end
         otsu_pkg::OP_SC_ACC: begin
            pb_ff <= pb_ff + TCW'(bin);
            ib_ff <= ib_ff + bin_w;
         end
         otsu_pkg::OP_DECIDE: begin
            // Strict compare keeps the lower level on a tie.
            if (first_ff || (lhs_ff > rhs_ff)) begin
               bsq_ff  <= sq_ff;
               bden_ff <= den_ff;
               thr_ff  <= idx_ff;
            end
            first_ff <= 1'b0;
            idx_ff   <= idx_ff + 8'd1;
         end
         default: ;
      endcase
   end

   assign stat.mul_busy  = mul_busy;
   assign stat.mul_done  = mul_done;
   assign stat.sweep_end = (idx_ff == otsu_pkg::LAST_BIN);
   assign stat.found     = found_ff;
   assign stat.narrow    = (hi_ff == lo_ff) || (hi_ff == (lo_ff + 8'd1));
   assign stat.scan_end  = ((idx_ff + 8'd1) == hi_ff);
   assign stat.threshold = thr_ff;
endmodule

### rtl/otsu_ctrl.sv
// Controller: sequences histogram update, sweep, scan and response.
module otsu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last_pixel,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_threshold,
   output otsu_pkg::dp_cmd_type  cmd,
   input  otsu_pkg::dp_stat_type stat
);
   typedef enum logic [3:0] {
      S_IDLE,
      S_INC,
      S_SW_INIT,
      S_SW_RD,
      S_SW_ACC,
      S_SW_END,
      S_SC_RD,
      S_SC_ACC,
      S_MGO,
      S_MWAIT,
      S_DECIDE,
      S_FINISH
   } state_type;

   state_type             state_ff, state_in;
   otsu_pkg::mul_sel_type mstep_ff, mstep_in, mstep_next;
   logic                  last_ff, last_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [7:0]            rsp_thr_ff, rsp_thr_in;
   logic                  accept;
   logic                  rsp_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_vld_ff || rsp_ready;

   always_comb begin
      unique case (mstep_ff)
         otsu_pkg::MS_P:   mstep_next = otsu_pkg::MS_Q;
         otsu_pkg::MS_Q:   mstep_next = otsu_pkg::MS_DEN;
         otsu_pkg::MS_DEN: mstep_next = otsu_pkg::MS_SQ;
         otsu_pkg::MS_SQ:  mstep_next = otsu_pkg::MS_LHS;
         otsu_pkg::MS_LHS: mstep_next = otsu_pkg::MS_RHS;
         default:          mstep_next = otsu_pkg::MS_RHS;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      mstep_in     = mstep_ff;
      last_in      = last_ff;
      rsp_thr_in   = rsp_thr_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_ready;
      cmd.op       = otsu_pkg::OP_NONE;
      cmd.msel     = mstep_ff;
      cmd.mul_go   = 1'b0;
      cmd.mul_take = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.op   = otsu_pkg::OP_LOAD;
               last_in  = req_last_pixel;
               state_in = S_INC;
            end
         end
         S_INC: begin
            cmd.op   = otsu_pkg::OP_INC;
            state_in = last_ff ? S_SW_INIT : S_IDLE;
         end
         S_SW_INIT: begin
            cmd.op   = otsu_pkg::OP_SW_INIT;
            state_in = S_SW_RD;
         end
         S_SW_RD: begin
            cmd.op   = otsu_pkg::OP_SW_RD;
            state_in = S_SW_ACC;
         end
         S_SW_ACC: begin
            cmd.op   = otsu_pkg::OP_SW_ACC;
            state_in = stat.sweep_end ? S_SW_END : S_SW_RD;
         end
         S_SW_END: begin
            cmd.op   = otsu_pkg::OP_SET_THR;
            state_in = (!stat.found || stat.narrow) ? S_FINISH : S_SC_RD;
         end
         S_SC_RD: begin
            cmd.op   = otsu_pkg::OP_SC_RD;
            state_in = S_SC_ACC;
         end
         S_SC_ACC: begin
            cmd.op   = otsu_pkg::OP_SC_ACC;
            mstep_in = otsu_pkg::MS_P;
            state_in = S_MGO;
         end
         S_MGO: begin
            cmd.mul_go = 1'b1;
            state_in   = S_MWAIT;
         end
         S_MWAIT: begin
            if (stat.mul_done) begin
               cmd.mul_take = 1'b1;
               if (mstep_ff == otsu_pkg::MS_RHS) begin
                  state_in = S_DECIDE;
               end else begin
                  mstep_in = mstep_next;
                  state_in = S_MGO;
               end
            end
         end
         S_DECIDE: begin
            cmd.op   = otsu_pkg::OP_DECIDE;
            state_in = stat.scan_end ? S_FINISH : S_SC_RD;
         end
         S_FINISH: begin
            if (rsp_free) begin
               cmd.op     = otsu_pkg::OP_CLEAR;
               rsp_vld_in = 1'b1;
               rsp_thr_in = stat.threshold;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         mstep_ff   <= otsu_pkg::MS_P;
         last_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
         rsp_thr_ff <= '0;
      end else begin
         state_ff   <= state_in;
         mstep_ff   <= mstep_in;
         last_ff    <= last_in;
         rsp_vld_ff <= rsp_vld_in;
         rsp_thr_ff <= rsp_thr_in;
      end
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_threshold = rsp_thr_ff;
endmodule

### rtl/otsu_threshold_finder_unit.sv
// Top level of the Otsu threshold finder: controller, datapath, assertions.
// Pixel requests: each is taken only in the idle state; its bin is read into a register, then written back.
// Frame end: a read-and-accumulate sweep over levels 0..254, then per scanned level a read, an
//   accumulate, six products on the shared bit-serial multiplier and a decision.
// The response sits in an output register; new pixels are taken while it waits.
// Reset (synchronous, active high) clears all histogram valid bits and the controller.
module otsu_threshold_finder_unit #(
   parameter int COUNT_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   otsu_req_if.sink          req_chan,
   otsu_rsp_if.source        rsp_chan
);
   // Command and status between controller and datapath.
   otsu_pkg::dp_cmd_type  cmd;
   otsu_pkg::dp_stat_type stat;

   // Sequence each pixel update, the min/max and totals sweep, and the variance scan.
   otsu_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_last_pixel (req_chan.last_pixel),
      .req_ready      (req_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_threshold  (rsp_chan.threshold),
      .cmd            (cmd),
      .stat           (stat)
   );

   // Hold the histogram and all sums; compare variances exactly by cross-multiplying.
   otsu_dp #(
      .COUNT_BITS(COUNT_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_pixel (req_chan.pixel),
      .cmd       (cmd),
      .stat      (stat)
   );

   // A product is taken only once the multiplier has finished.
   a_take_done: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_take |-> stat.mul_done)
      else $error("product taken before multiplier finished");

   // The multiplier is never restarted while it is still working.
   a_go_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_go |-> !stat.mul_busy)
      else $error("multiplier started while busy");

   // A histogram update always follows an accepted pixel request.
   a_inc_after_req: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == otsu_pkg::OP_INC) |-> $past(req_chan.valid && req_chan.ready))
      else $error("histogram update without accepted request");
endmodule

### sim/otsu_threshold_finder_unit_tb.sv
// Otsu threshold finder testbench: directed and random frames checked against expected thresholds.
`timescale 1ns / 100ps

module otsu_threshold_finder_unit_tb;

   // A narrow bin width keeps saturation reachable with a few hundred pixels.
   localparam int COUNT_BITS    = 8;
   localparam int BIN_MAX       = (1 << COUNT_BITS) - 1;
   localparam int TARGET_PIXELS = 1950;
   localparam int STALL_LIMIT   = 300000;
   localparam int LONG_HOLD     = 3000;

   typedef struct {
      logic [7:0] pixel;
      bit         last_pixel;
      int         reps;       // pixel repeated; last flag only on the final copy
      bit         known;      // threshold typed in below instead of predicted
      logic [7:0] threshold;
   } frame_row_type;

   logic clock;
   logic reset;

   otsu_req_if req_chan ();
   otsu_rsp_if rsp_chan ();

   otsu_threshold_finder_unit #(.COUNT_BITS(COUNT_BITS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor state: a shadow histogram of the frame being collected.
   int            grey_bins[256];
   logic [7:0]    pending_thresholds[$];
   int            error_count;
   int            pixels_sent;
   int            responses_seen;
   int            idle_cycles;
   frame_row_type frame_rows[$];

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
      $display("%0t: %s threshold got %0d want %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Otsu search over the shadow histogram, exact in wide integers.
   function automatic logic [7:0] otsu_level();
      int                lo;
      int                hi;
      logic [7:0]        best_level;
      longint unsigned   total_cnt;
      longint unsigned   total_sum;
      longint unsigned   back_cnt;
      longint unsigned   back_sum;
      longint unsigned   prod_b;
      longint unsigned   prod_t;
      logic [191:0]      spread;
      logic [191:0]      split_den;
      logic [191:0]      best_spread;
      logic [191:0]      best_den;
      logic [191:0]      lhs;
      logic [191:0]      rhs;
      lo = 0;
      hi = 254;
      best_level = 8'd0;
      while (lo < 255 && grey_bins[lo] == 0) lo++;
      if (lo == 255) return 8'd0;
      while (hi > lo && grey_bins[hi] == 0) hi--;
      if (hi == lo || lo + 1 == hi) return lo[7:0];
      total_cnt = 0;
      total_sum = 0;
      for (int y = lo; y <= hi; y++) begin
         total_cnt += grey_bins[y];
         total_sum += longint'(grey_bins[y]) * y;
      end
      back_cnt = 0;
      back_sum = 0;
      best_spread = '0;
      best_den = '0;
      for (int y = lo; y < hi; y++) begin
         back_cnt += grey_bins[y];
         back_sum += longint'(grey_bins[y]) * y;
         split_den = 192'(back_cnt * (total_cnt - back_cnt));
         prod_b = back_sum * total_cnt;
         prod_t = total_sum * back_cnt;
         spread = (prod_b >= prod_t) ? 192'(prod_b - prod_t) : 192'(prod_t - prod_b);
         if (y == lo) begin
            best_spread = spread;
            best_den = split_den;
            best_level = y[7:0];
         end else begin
            lhs = spread * spread * best_den;
            rhs = best_spread * best_spread * split_den;
            // strictly greater: ties keep the lower level
            if (lhs > rhs) begin
               best_spread = spread;
               best_den = split_den;
               best_level = y[7:0];
            end
         end
      end
      return best_level;
   endfunction

   // Count one accepted pixel; on the frame's last pixel, queue its threshold.
   task automatic take_pixel(input logic [7:0] pix, input bit last, input bit known,
                             input logic [7:0] typed);
      logic [7:0] level;
      if (pix != otsu_pkg::PIX_SKIP && grey_bins[pix] < BIN_MAX) grey_bins[pix]++;
      if (last) begin
         level = otsu_level();
         pending_thresholds.push_back(known ? typed : level);
         foreach (grey_bins[i]) grey_bins[i] = 0;
      end
   endtask

   // Offer one request after a random gap and hold it until accepted.
   task automatic send_pixel(input logic [7:0] pix, input bit last, input bit known,
                             input logic [7:0] typed);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.pixel = pix;
      req_chan.last_pixel = last;
      do @(posedge clock); while (!req_chan.ready);
      take_pixel(pix, last, known, typed);
      pixels_sent++;
      @(negedge clock);
   endtask

   // Hold the sender until every queued threshold has come back.
   task automatic wait_drained();
      req_chan.valid = 1'b0;
      while (pending_thresholds.size() != 0) @(negedge clock);
   endtask

   task automatic send_random_frame();
      int         len;
      int         base;
      int         span;
      int         offset;
      bit         wide;
      logic [7:0] pix;
      len = $urandom_range(1, 40);
      // wide frames can scan nearly all levels and are slow, so keep them rare
      wide = ($urandom_range(0, 49) == 0);
      base = $urandom_range(0, 254);
      span = wide ? 254 : $urandom_range(0, 6);
      for (int k = 0; k < len; k++) begin
         offset = base + $urandom_range(0, span);
         if ($urandom_range(0, 15) == 0) pix = otsu_pkg::PIX_SKIP;
         else if (wide) pix = 8'($urandom_range(0, 254));
         else pix = (offset > 254) ? 8'd254 : 8'(offset);
         send_pixel(pix, k == len - 1, 1'b0, 8'd0);
      end
   endtask

   // Response side: random ready gaps, one long hold-off to fill the block.
   initial begin
      int wait_cycles;
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         wait_cycles = (responses_seen == 4) ? LONG_HOLD : $urandom_range(0, 5);
         if (wait_cycles > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
      end
   end

   // Check every accepted response against the oldest queued threshold.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         responses_seen++;
         if (pending_thresholds.size() == 0) begin
            report("unexpected", rsp_chan.threshold, 8'd0);
         end else begin
            if (rsp_chan.threshold !== pending_thresholds[0])
               report("wrong", rsp_chan.threshold, pending_thresholds[0]);
            void'(pending_thresholds.pop_front());
         end
      end
   end

   // Watchdog: abort after too long without any handshake.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("otsu_threshold_finder_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin
      error_count = 0;
      pixels_sent = 0;
      responses_seen = 0;
      idle_cycles = 0;
      foreach (grey_bins[i]) grey_bins[i] = 0;
      req_chan.valid = 1'b0;
      req_chan.pixel = 8'd0;
      req_chan.last_pixel = 1'b0;
      reset = 1'b1;

      // empty frame: only an uncounted level
      frame_rows.push_back('{otsu_pkg::PIX_SKIP, 1, 1, 1, 8'd0});
      // one occupied level at each extreme
      frame_rows.push_back('{8'd0, 1, 1, 1, 8'd0});
      frame_rows.push_back('{8'd254, 1, 1, 1, 8'd254});
      // adjacent levels give the lower one
      frame_rows.push_back('{8'd5, 0, 3, 0, 8'd0});
      frame_rows.push_back('{8'd6, 1, 1, 1, 8'd5});
      // level 255 in the middle of a frame is ignored
      frame_rows.push_back('{8'd128, 0, 2, 0, 8'd0});
      frame_rows.push_back('{otsu_pkg::PIX_SKIP, 0, 1, 0, 8'd0});
      frame_rows.push_back('{8'd128, 1, 1, 1, 8'd128});
      // equal variance everywhere between two levels: the lowest split wins
      frame_rows.push_back('{8'd10, 0, 1, 0, 8'd0});
      frame_rows.push_back('{8'd20, 1, 1, 1, 8'd10});
      // full-range scan
      frame_rows.push_back('{8'd0, 0, 4, 0, 8'd0});
      frame_rows.push_back('{8'd77, 0, 2, 0, 8'd0});
      frame_rows.push_back('{8'd254, 1, 3, 0, 8'd0});
      // bin saturation
      frame_rows.push_back('{8'd20, 0, BIN_MAX + 45, 0, 8'd0});
      frame_rows.push_back('{8'd21, 0, 1, 0, 8'd0});
      frame_rows.push_back('{8'd40, 1, 1, 0, 8'd0});
      // walking one over pixel bits 0 to 6
      frame_rows.push_back('{8'd1, 0, 1, 0, 8'd0});
      frame_rows.push_back('{8'd2, 0, 1, 0, 8'd0});
      frame_rows.push_back('{8'd4, 0, 1, 0, 8'd0});
      frame_rows.push_back('{8'd8, 0, 1, 0, 8'd0});
      frame_rows.push_back('{8'd16, 0, 1, 0, 8'd0});
      frame_rows.push_back('{8'd32, 0, 1, 0, 8'd0});
      frame_rows.push_back('{8'd64, 1, 1, 0, 8'd0});

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (frame_rows[r]) begin
         for (int k = 0; k < frame_rows[r].reps; k++)
            send_pixel(frame_rows[r].pixel,
                       frame_rows[r].last_pixel && (k == frame_rows[r].reps - 1),
                       frame_rows[r].known, frame_rows[r].threshold);
      end
      wait_drained();

      while (pixels_sent < TARGET_PIXELS) begin
         // now and then let the block drain completely between frames
         if ($urandom_range(0, 9) == 0) wait_drained();
         send_random_frame();
      end

      req_chan.valid = 1'b0;
      wait_drained();
      repeat (100) @(posedge clock);
      if (error_count == 0 && pending_thresholds.size() == 0) begin
         $display("otsu_threshold_finder_unit: match");
      end else begin
         $display("otsu_threshold_finder_unit: mismatch");
      end
      $finish;
   end

endmodule

### sim.f
rtl/otsu_pkg.sv
rtl/otsu_req_if.sv
rtl/otsu_rsp_if.sv
rtl/otsu_mul.sv
rtl/otsu_dp.sv
rtl/otsu_ctrl.sv
rtl/otsu_threshold_finder_unit.sv
sim/otsu_threshold_finder_unit_tb.sv
